FILE: rtl/tte_pkg.sv
// Shared types, constants and helpers for the threshold and 3x3 erosion block.
// Used by every module of threshold_then_erode_3x3; depends on nothing.
`default_nettype none

package tte_pkg;

  // Frame limits and the widths that follow from them
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Configuration register indexes and widths
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_AW-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_AW-1:0] REG_HEIGHT    = 2'd2;
  localparam int THR_W  = 32;
  localparam int WCFG_W = 11;
  localparam int HCFG_W = 13;
  localparam logic signed [THR_W-1:0] THR_RESET  = 32'sd32768;
  localparam logic [WCFG_W-1:0]       WCFG_RESET = 11'd1024;
  localparam logic [HCFG_W-1:0]       HCFG_RESET = 13'd1024;

  // Result kinds
  localparam logic KIND_BINARY = 1'b0;
  localparam logic KIND_CONF   = 1'b1;

  // Most results one input word can cause
  localparam int MAX_RES = 4;
  localparam int RIDX_W  = $clog2(MAX_RES);

  // One input word after the threshold, with its position and frame bounds
  typedef struct packed {
    logic             b;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic             row_end;
    logic             last_row;
  } tte_item_t;

  // One result word
  typedef struct packed {
    logic             kind;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             pix_bit;
  } tte_res_t;

  // The results of one input word, slot 0 first
  typedef struct packed {
    tte_res_t [MAX_RES-1:0] slot;
    logic [RIDX_W-1:0]      last_idx;
  } tte_set_t;

  // Line buffer write request: {bit two rows up, bit one row up}
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [1:0]       data;
  } tte_lb_wr_t;

  // Width register to last column index: zero counts as one, large values saturate
  function automatic logic [COL_W-1:0] width_m1(input logic [WCFG_W-1:0] v);
    logic [COL_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > WCFG_W'(MAX_WIDTH)) begin
      res = COL_W'(MAX_WIDTH - 1);
    end else begin
      res = COL_W'(v - 1'b1);
    end
    return res;
  endfunction

  // Height register to last row index, same rules
  function automatic logic [ROW_W-1:0] height_m1(input logic [HCFG_W-1:0] v);
    logic [ROW_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > HCFG_W'(MAX_HEIGHT)) begin
      res = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      res = ROW_W'(v - 1'b1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tte_line_buf.sv
// Two-row line buffer: one synchronous 2-bit-wide memory, one entry per column.
// Clears itself after reset; forwards a same-edge write to the read port. Uses tte_pkg.
`default_nettype none

module tte_line_buf (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      rd_en,
  input  wire logic [tte_pkg::COL_W-1:0] rd_addr,
  input  wire tte_pkg::tte_lb_wr_t       wr,
  output logic [1:0]                     rd_data,
  output logic                           clearing
);

  logic [1:0]                mem [tte_pkg::MAX_WIDTH];
  logic [1:0]                rd_data_r;
  logic                      clearing_r;
  logic [tte_pkg::COL_W-1:0] clr_cnt_r;
  logic                      we;
  logic [tte_pkg::COL_W-1:0] waddr;
  logic [1:0]                wdata;

  // Clearing pass after reset: one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == tte_pkg::COL_W'(tte_pkg::MAX_WIDTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Pick the write: clearing pass or write-back
  always_comb begin
    we    = clearing_r | wr.en;
    waddr = clearing_r ? clr_cnt_r : wr.addr;
    wdata = clearing_r ? 2'b00 : wr.data;
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; forward a write to the same entry on the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data_r <= wr.data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

`ifndef SYNTHESIS
  // No column read may start before the clearing pass is over
  a_no_read_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !clearing_r)
    else $error("line buffer read during clearing pass");
`endif

endmodule

`default_nettype wire

FILE: rtl/tte_erode.sv
// Window stage: takes the line buffer read, updates the 3x3 window, writes the
// column back and forms the result set of one word. Uses tte_pkg.
`default_nettype none

module tte_erode (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire tte_pkg::tte_item_t item,
  input  wire logic [1:0]         rd_data,
  input  wire logic               load_ok,
  output tte_pkg::tte_lb_wr_t     wr,
  output logic                    set_valid,
  output tte_pkg::tte_set_t       set
);

  logic               s1_v_r;
  logic               s1_v_nxt;
  tte_pkg::tte_item_t s1_r;
  logic [8:0]         window_r;
  logic [8:0]         window_nxt;
  logic               adv;
  logic               up2;
  logic               up1;
  logic               inner;
  logic [2:0]         n;
  tte_pkg::tte_res_t  res;

  assign up2 = rd_data[1];
  assign up1 = rd_data[0];
  assign adv = s1_v_r & load_ok;

  // Hold the word until its results are taken over by the output stage
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      window_r <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (adv) begin
        window_r <= window_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= item;
    end
  end

  // Shift in the newest column: bit two rows up, one row up, this row
  assign window_nxt = {window_r[5:0], up2, up1, s1_r.b};

  assign inner = (s1_r.col >= tte_pkg::COL_W'(2)) && (s1_r.row >= tte_pkg::ROW_W'(2)) &&
                 (s1_r.col <= s1_r.w_m1) && (s1_r.row <= s1_r.h_m1);

  // Write the column back: this row moves up one
  always_comb begin
    wr.en   = adv;
    wr.addr = s1_r.col;
    wr.data = {up1, s1_r.b};
  end

  // Assemble the result set in order
  always_comb begin
    set = '0;
    n   = 3'd0;
    res = '0;

    // binary result for the word itself
    res.kind    = tte_pkg::KIND_BINARY;
    res.col     = s1_r.col;
    res.row     = s1_r.row;
    res.pix_bit = s1_r.b;
    set.slot[n[tte_pkg::RIDX_W-1:0]] = res;
    n = n + 3'd1;

    // confidence for the centre one row and one column back
    if ((s1_r.col != '0) && (s1_r.row != '0)) begin
      res.kind    = tte_pkg::KIND_CONF;
      res.col     = s1_r.col - 1'b1;
      res.row     = s1_r.row - 1'b1;
      res.pix_bit = inner && (window_nxt == 9'h1ff);
      set.slot[n[tte_pkg::RIDX_W-1:0]] = res;
      n = n + 3'd1;
    end else if ((s1_r.col == '0) && (s1_r.row >= tte_pkg::ROW_W'(2))) begin
      // right border pixel of the row two above
      res.kind    = tte_pkg::KIND_CONF;
      res.col     = s1_r.w_m1;
      res.row     = s1_r.row - tte_pkg::ROW_W'(2);
      res.pix_bit = 1'b0;
      set.slot[n[tte_pkg::RIDX_W-1:0]] = res;
      n = n + 3'd1;
    end

    // last row: flush the border zeros as it streams in
    if (s1_r.last_row) begin
      if (s1_r.row_end && (s1_r.row != '0)) begin
        res.kind    = tte_pkg::KIND_CONF;
        res.col     = s1_r.w_m1;
        res.row     = s1_r.row - 1'b1;
        res.pix_bit = 1'b0;
        set.slot[n[tte_pkg::RIDX_W-1:0]] = res;
        n = n + 3'd1;
      end
      res.kind    = tte_pkg::KIND_CONF;
      res.col     = s1_r.col;
      res.row     = s1_r.row;
      res.pix_bit = 1'b0;
      set.slot[n[tte_pkg::RIDX_W-1:0]] = res;
      n = n + 3'd1;
    end

    set.last_idx = tte_pkg::RIDX_W'(n - 3'd1);
  end

  assign set_valid = s1_v_r;

`ifndef SYNTHESIS
  // A waiting word stays until the output stage takes its results
  a_hold_until_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !load_ok) |=> s1_v_r)
    else $error("window stage dropped a word");

  // The window moves only when a word leaves the stage
  a_window_moves_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(window_r))
    else $error("window changed without a word");
`endif

endmodule

`default_nettype wire

FILE: rtl/tte_out_seq.sv
// Output sequencer: holds the result set of one word and sends it one word per
// cycle while out_tready is high, marking the final one with tlast. Uses tte_pkg.
`default_nettype none

module tte_out_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              set_valid,
  input  wire tte_pkg::tte_set_t set,
  output logic                   load_ok,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [23:0]            out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  tte_pkg::tte_res_t          slot_r [tte_pkg::MAX_RES];
  logic [tte_pkg::RIDX_W-1:0] last_idx_r;
  logic [tte_pkg::RIDX_W-1:0] idx_r;
  logic                       busy_r;
  logic                       busy_nxt;
  logic [tte_pkg::RIDX_W-1:0] idx_nxt;
  logic                       take;
  logic                       at_last;
  logic                       load;
  tte_pkg::tte_res_t          cur;

  assign take    = busy_r & out_tready;
  assign at_last = (idx_r == last_idx_r);
  assign load_ok = ~busy_r | (take & at_last);
  assign load    = load_ok & set_valid;

  // Advance through the slots; reload when the last one goes
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (take) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < tte_pkg::MAX_RES; i++) begin
        slot_r[i] <= set.slot[i];
      end
      last_idx_r <= set.last_idx;
    end
  end

  // Drive the current word
  assign cur        = slot_r[idx_r];
  assign out_tvalid = busy_r;
  assign out_tdata  = {1'b0, cur.pix_bit, cur.row, cur.col};
  assign out_tuser  = cur.kind;
  assign out_tlast  = at_last;

`ifndef SYNTHESIS
  // A stalled word keeps its slot
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_tready) |=> (busy_r && $stable(idx_r)))
    else $error("result slot moved while stalled");
`endif

endmodule

`default_nettype wire

FILE: rtl/threshold_then_erode_3x3.sv
// Top level: threshold of a Q16.16 pixel stream and a 3x3 erosion of the result.
// Holds the configuration registers and raster counters; uses tte_pkg, tte_line_buf,
// tte_erode and tte_out_seq.
//
//   port group | direction | payload
//   in_*       | in        | tdata[31:0] sample
//   out_*      | out       | tdata[9:0] col, [21:10] row, [22] bit; tuser kind; tlast
//   cfg_*      | in        | addr 0 threshold, 1 width, 2 height; wdata[31:0]
//
// A word is accepted and its column read from the line buffer on one edge; its
// results go into the output slots when load_ok allows and leave one per cycle
// while out_tready is high. Each word causes one to four results, two in the body
// of a frame. After reset the line buffer clears all its entries with in_tready low.
// A stalled output holds its word; a new word is still taken into the window stage
// while one waits at the output, but not while the window stage holds one.
`default_nettype none

module threshold_then_erode_3x3 (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [31:0]                in_tdata,   // [31:0] sample
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [23:0]                     out_tdata,  // [9:0] pixel_col, [21:10] pixel_row,
                                                      // [22] pixel_bit, [23] zero
  output logic                            out_tuser,  // [0] map_kind
  output logic                            out_tlast,
  input  wire logic                       cfg_we,
  input  wire logic [tte_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [31:0]                cfg_wdata
);

  logic signed [tte_pkg::THR_W-1:0] thr_r;
  logic [tte_pkg::WCFG_W-1:0]       wcfg_r;
  logic [tte_pkg::HCFG_W-1:0]       hcfg_r;
  logic [tte_pkg::COL_W-1:0]        col_r;
  logic [tte_pkg::COL_W-1:0]        col_nxt;
  logic [tte_pkg::ROW_W-1:0]        row_r;
  logic [tte_pkg::ROW_W-1:0]        row_nxt;
  logic                             accept;
  logic                             clearing;
  logic                             set_valid;
  logic                             load_ok;
  logic [1:0]                       rd_data;
  tte_pkg::tte_item_t               item;
  tte_pkg::tte_lb_wr_t              wr;
  tte_pkg::tte_set_t                set;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= tte_pkg::THR_RESET;
      wcfg_r <= tte_pkg::WCFG_RESET;
      hcfg_r <= tte_pkg::HCFG_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        tte_pkg::REG_THRESHOLD: thr_r  <= $signed(cfg_wdata);
        tte_pkg::REG_WIDTH:     wcfg_r <= cfg_wdata[tte_pkg::WCFG_W-1:0];
        tte_pkg::REG_HEIGHT:    hcfg_r <= cfg_wdata[tte_pkg::HCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Threshold and raster position of the incoming word
  always_comb begin
    item.b        = $signed(in_tdata) >= thr_r;
    item.col      = col_r;
    item.row      = row_r;
    item.w_m1     = tte_pkg::width_m1(wcfg_r);
    item.h_m1     = tte_pkg::height_m1(hcfg_r);
    item.row_end  = col_r >= item.w_m1;
    item.last_row = row_r >= item.h_m1;
  end

  assign in_tready = ~clearing & (~set_valid | load_ok);
  assign accept    = in_tvalid & in_tready;

  // Advance the raster counters; wrap at row and frame end
  always_comb begin
    col_nxt = col_r + 1'b1;
    row_nxt = row_r;
    if (item.row_end) begin
      col_nxt = '0;
      row_nxt = item.last_row ? '0 : row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  tte_line_buf u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (col_r),
    .wr       (wr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  tte_erode u_erode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (item),
    .rd_data   (rd_data),
    .load_ok   (load_ok),
    .wr        (wr),
    .set_valid (set_valid),
    .set       (set)
  );

  tte_out_seq u_out_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .set_valid  (set_valid),
    .set        (set),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
